/* design/elog10_pkg.sv */
// Shared constants for the elementwise log10 stream core.
// Holds the log2 fraction width, the log10(2) scale factor and the status codes.
// No dependencies.
`default_nettype none

package elog10_pkg;

  parameter int LOG2_FRAC = 28;
  parameter logic [31:0] LOG10_2 = 32'h4D10_4D42;

  typedef enum logic [1:0] {
    ST_LOG  = 2'd0,
    ST_ZERO = 2'd1,
    ST_NEG  = 2'd2,
    ST_PASS = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* design/elog10_norm.sv */
// Leading-one normalizer: shifts a positive sample left by four or one bit
// per cycle until its leading one reaches the top, counting the shift.
// Depends on nothing.
`default_nettype none

module elog10_norm #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DATA_WIDTH-2:0]         sample,
  output logic                          done,
  output logic [31:0]                   mant,
  output logic [$clog2(DATA_WIDTH)-1:0] lead_shift
);

  localparam int X_W = DATA_WIDTH - 1;
  localparam int CW  = $clog2(DATA_WIDTH);

  logic [X_W-1:0]    x_r;
  logic [CW-1:0]     k_r;
  logic              busy_r;
  logic              done_r;
  logic [X_W+31:0]   wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && x_r[X_W-1]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= sample;
      k_r <= '0;
    end else if (busy_r && !x_r[X_W-1]) begin
      if (x_r[X_W-1 -: 4] == 4'b0000) begin
        x_r <= x_r << 4;
        k_r <= k_r + CW'(4);
      end else begin
        x_r <= x_r << 1;
        k_r <= k_r + CW'(1);
      end
    end
  end

  assign wide       = {x_r, 32'b0};
  assign mant       = wide[X_W+31 -: 32];
  assign lead_shift = k_r;
  assign done       = done_r;

endmodule

`default_nettype wire

/* design/elog10_sqlog.sv */
// Log2 fraction unit: repeated squaring of a Q1.31 mantissa through one
// 32x32 multiplier, one fraction bit per cycle.
// Depends on elog10_pkg.
`default_nettype none

module elog10_sqlog (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [31:0]                     mant,
  output logic                            done,
  output logic [elog10_pkg::LOG2_FRAC-1:0] frac
);

  localparam int FW    = elog10_pkg::LOG2_FRAC;
  localparam int CNT_W = $clog2(FW);

  logic [31:0]    m_r;
  logic [FW-1:0]  frac_r;
  logic [CNT_W-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [63:0]    q;

  assign q = m_r * m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(FW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r    <= mant;
      frac_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      frac_r <= {frac_r[FW-2:0], q[63]};
      m_r    <= q[63] ? q[63:32] : q[62:31];
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  assign frac = frac_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* design/elog10_scale.sv */
// Scaling unit: builds the signed Q.28 log2, multiplies it by log10(2) one
// 4-bit digit per cycle, then rounds and saturates to the output format.
// Depends on elog10_pkg.
`default_nettype none

module elog10_scale #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [$clog2(DATA_WIDTH)-1:0]    lead_shift,
  input  logic [elog10_pkg::LOG2_FRAC-1:0] frac,
  output logic                             done,
  output logic [DATA_WIDTH-1:0]            value
);

  localparam int FW      = elog10_pkg::LOG2_FRAC;
  localparam int CW      = $clog2(DATA_WIDTH);
  localparam int PBASE   = DATA_WIDTH - 2 - FRAC_BITS;
  localparam int IP_W    = $clog2(DATA_WIDTH + FRAC_BITS) + 1;
  localparam int MAG_W   = IP_W - 1 + FW;
  localparam int ND      = (MAG_W + 3) / 4;
  localparam int DIG_TOT = ND * 4;
  localparam int ACC_W   = DIG_TOT + 32;
  localparam int SH      = FW + 32 - FRAC_BITS;
  localparam int R_W     = ACC_W + 1 - SH;
  localparam int CMP_W   = ((R_W > DATA_WIDTH) ? R_W : DATA_WIDTH) + 1;
  localparam int DC_W    = $clog2(ND + 1);
  localparam logic [ACC_W:0]   HALF   = (ACC_W + 1)'(1) << (SH - 1);
  localparam logic [CMP_W-1:0] MAXPOS =
    {{(CMP_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [CMP_W-1:0] MAXNEG = MAXPOS + CMP_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RND} state_t;

  state_t              state_r;
  logic                done_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [DIG_TOT-1:0]  mag_r;
  logic [ACC_W-1:0]    acc_r;
  logic [DC_W-1:0]     dcnt_r;
  logic                neg_r;

  logic [IP_W-1:0]     ip;
  logic                ip_neg;
  logic [IP_W-1:0]     ip_abs;
  logic [MAG_W-1:0]    mag_base;
  logic [MAG_W-1:0]    mag;
  logic [35:0]         pp;
  logic [ACC_W:0]      rnd;
  logic [R_W-1:0]      r;
  logic [CMP_W-1:0]    r_ext;
  logic [CMP_W-1:0]    lim;
  logic [CMP_W-1:0]    rs;

  always_comb begin
    ip       = IP_W'(PBASE) - IP_W'(lead_shift);
    ip_neg   = ip[IP_W-1];
    ip_abs   = ip_neg ? (IP_W'(0) - ip) : ip;
    mag_base = {ip_abs[IP_W-2:0], {FW{1'b0}}};
    mag      = ip_neg ? (mag_base - MAG_W'(frac)) : (mag_base + MAG_W'(frac));
    pp       = 36'(elog10_pkg::LOG10_2) * 36'(mag_r[DIG_TOT-1 -: 4]);
    rnd      = {1'b0, acc_r} + HALF;
    r        = rnd[ACC_W:SH];
    r_ext    = CMP_W'(r);
    lim      = neg_r ? MAXNEG : MAXPOS;
    rs       = (r_ext > lim) ? lim : r_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            mag_r   <= DIG_TOT'(mag);
            neg_r   <= ip_neg;
            acc_r   <= '0;
            dcnt_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r  <= (acc_r << 4) + ACC_W'(pp);
          mag_r  <= mag_r << 4;
          dcnt_r <= dcnt_r + DC_W'(1);
          if (dcnt_r == DC_W'(ND - 1)) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          value_r <= neg_r ? DATA_WIDTH'(CMP_W'(0) - rs) : DATA_WIDTH'(rs);
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

`default_nettype wire

/* design/elementwise_log10_stream_core.sv */
// Elementwise log10 of a matrix streamed as signed fixed-point samples, one
// result per sample. A zero sample, a negative sample and any sample after a
// negative one in the same matrix bypass the log units; a positive sample goes
// through the normalize steps, the most for small values, 28 squaring steps
// through the one 32x32 multiplier, 9 digit steps of the log10(2) scale at
// DATA_WIDTH 32, and a round step. One sample is in work at a time; the output
// register lets the next sample transfer while a result waits. Depends on
// elog10_pkg, elog10_norm, elog10_sqlog and elog10_scale.
`default_nettype none

module elementwise_log10_stream_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     in_tdata,  // sample
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     out_tdata, // value
  output logic [1:0]                          out_tuser, // status
  output logic                                out_tlast
);

  localparam int TD_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int CW   = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {C_IDLE, C_WORK, C_HOLD} state_t;

  state_t                  state_r;
  logic                    err_r;
  logic [DATA_WIDTH-1:0]   res_r;
  elog10_pkg::status_t     st_r;
  logic                    last_r;
  logic                    out_tvalid_r;
  logic [DATA_WIDTH-1:0]   out_value_r;
  elog10_pkg::status_t     out_status_r;
  logic                    out_last_r;

  logic [DATA_WIDTH-1:0]   s;
  logic                    s_zero;
  logic                    s_neg;
  logic                    in_xfer;
  logic                    out_free;
  logic                    norm_start;
  logic                    norm_done;
  logic [31:0]             mant;
  logic [CW-1:0]           lead_shift;
  logic                    sq_done;
  logic [elog10_pkg::LOG2_FRAC-1:0] frac;
  logic                    scale_done;
  logic [DATA_WIDTH-1:0]   scale_value;

  assign s          = in_tdata[DATA_WIDTH-1:0];
  assign s_zero     = (s == '0);
  assign s_neg      = s[DATA_WIDTH-1];
  assign in_tready  = (state_r == C_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign norm_start = in_xfer && !err_r && !s_zero && !s_neg;

  elog10_norm #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (norm_start),
    .sample    (s[DATA_WIDTH-2:0]),
    .done      (norm_done),
    .mant      (mant),
    .lead_shift(lead_shift)
  );

  elog10_sqlog u_sqlog (
    .clk  (clk),
    .rst_n(rst_n),
    .start(norm_done),
    .mant (mant),
    .done (sq_done),
    .frac (frac)
  );

  elog10_scale #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sq_done),
    .lead_shift(lead_shift),
    .frac      (frac),
    .done      (scale_done),
    .value     (scale_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= C_IDLE;
      err_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == C_HOLD && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        C_IDLE: begin
          if (in_xfer) begin
            last_r <= in_tlast;
            err_r  <= !in_tlast && (err_r || s_neg);
            if (err_r) begin
              res_r   <= s;
              st_r    <= elog10_pkg::ST_PASS;
              state_r <= C_HOLD;
            end else if (s_zero) begin
              res_r   <= '0;
              st_r    <= elog10_pkg::ST_ZERO;
              state_r <= C_HOLD;
            end else if (s_neg) begin
              res_r   <= s;
              st_r    <= elog10_pkg::ST_NEG;
              state_r <= C_HOLD;
            end else begin
              st_r    <= elog10_pkg::ST_LOG;
              state_r <= C_WORK;
            end
          end
        end
        C_WORK: begin
          if (scale_done) begin
            res_r   <= scale_value;
            state_r <= C_HOLD;
          end
        end
        C_HOLD: begin
          if (out_free) begin
            out_value_r  <= res_r;
            out_status_r <= st_r;
            out_last_r   <= last_r;
            state_r      <= C_IDLE;
          end
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TD_W'(out_value_r);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for elementwise_log10_stream_core: streams matrices of Q16.16 samples,
// predicts log10 / zero / error / abort results and checks every result transfer.
// Depends on elog10_pkg and the core.

module tb;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int TW = ((DW + 7) / 8) * 8;
  localparam int CALM_TAIL = 60;
  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [DW-1:0] sample;
    logic          last;
    bit            hold;
  } sample_t;

  typedef struct {
    logic [DW-1:0]       value;
    elog10_pkg::status_t status;
    logic                last;
  } result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [TW-1:0] in_tdata = '0;
  logic          in_tlast = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [TW-1:0] out_tdata;
  logic [1:0]    out_tuser;
  logic          out_tlast;

  sample_t samples_q[$];
  result_t results_due_q[$];
  bit      matrix_aborted = 1'b0;
  int      fail_count = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  longint  cycle_count = 0;

  elementwise_log10_stream_core #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [DW-1:0] log10_fixed(input logic [DW-1:0] s);
    int          lead;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] frac;
    logic [63:0] mag;
    logic [63:0] rnd;
    logic [63:0] maxpos;
    logic [63:0] neg_bits;
    longint      ip;
    lead = 0;
    frac = 64'd0;
    for (int i = 0; i < DW; i++) begin
      if (s[i]) lead = i;
    end
    if (lead >= 31) m = 64'(s) >> (lead - 31);
    else m = 64'(s) << (31 - lead);
    for (int i = 0; i < elog10_pkg::LOG2_FRAC; i++) begin
      q = m * m;
      if (q[63]) begin
        frac = (frac << 1) | 64'd1;
        m = q >> 32;
      end else begin
        frac = frac << 1;
        m = q >> 31;
      end
    end
    ip = longint'(lead) - longint'(FB);
    if (ip >= 0) mag = (64'(ip) << elog10_pkg::LOG2_FRAC) + frac;
    else mag = (64'(-ip) << elog10_pkg::LOG2_FRAC) - frac;
    mag = mag * 64'(elog10_pkg::LOG10_2);
    rnd = (mag + (64'd1 << (elog10_pkg::LOG2_FRAC + 32 - FB - 1)))
          >> (elog10_pkg::LOG2_FRAC + 32 - FB);
    maxpos = (64'd1 << (DW - 1)) - 64'd1;
    if (ip < 0) begin
      if (rnd > maxpos + 64'd1) rnd = maxpos + 64'd1;
      neg_bits = 64'd0 - rnd;
      return neg_bits[DW-1:0];
    end
    if (rnd > maxpos) rnd = maxpos;
    return rnd[DW-1:0];
  endfunction

  function automatic result_t log10_step(input sample_t item);
    result_t r;
    r.last = item.last;
    if (matrix_aborted) begin
      r.value = item.sample;
      r.status = elog10_pkg::ST_PASS;
    end else if (item.sample == '0) begin
      r.value = '0;
      r.status = elog10_pkg::ST_ZERO;
    end else if (item.sample[DW-1]) begin
      r.value = item.sample;
      r.status = elog10_pkg::ST_NEG;
      matrix_aborted = 1'b1;
    end else begin
      r.value = log10_fixed(item.sample);
      r.status = elog10_pkg::ST_LOG;
    end
    if (item.last) matrix_aborted = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
    fail_count++;
  endtask

  task automatic add_sample(input logic [DW-1:0] s, input logic last, input bit hold);
    sample_t item;
    item.sample = s;
    item.last = last;
    item.hold = hold;
    samples_q.insert(samples_q.size(), item);
  endtask

  function automatic logic [DW-1:0] rand_positive();
    int          sh;
    logic [63:0] bits;
    sh = $urandom_range(0, DW - 2);
    bits = {$urandom, $urandom};
    bits = (bits & ((64'd1 << (sh + 1)) - 64'd1)) | (64'd1 << sh);
    return bits[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] rand_negative();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    bits[DW-1] = 1'b1;
    return bits[DW-1:0];
  endfunction

  task automatic add_matrix(input bit hold_first);
    int            len;
    int            pick;
    bit            clean;
    logic [DW-1:0] s;
    len = $urandom_range(1, 12);
    clean = $urandom_range(0, 9) < 7;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (!clean && pick < 3) s = rand_negative();
      else if (pick == 3) s = '0;
      else s = rand_positive();
      add_sample(s, i == len - 1, hold_first && i == 0);
    end
  endtask

  // driver: present queued samples, predict each one on its transfer
  always @(posedge clk) begin : driver
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        results_due_q.insert(results_due_q.size(), log10_step(samples_q[0]));
        void'(samples_q.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (samples_q.size() > 0 &&
                     !(samples_q[0].hold && results_due_q.size() != 0)) begin
          if (samples_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            in_gap = $urandom_range(1, 9) - 1;
          end else begin
            nxt_valid = 1'b1;
            in_tdata <= TW'(samples_q[0].sample);
            in_tlast <= samples_q[0].last;
          end
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[DW-1:0], '0);
        end else begin
          want = results_due_q.pop_front();
          if (out_tdata[DW-1:0] !== want.value)
            report_mismatch("value", out_tdata[DW-1:0], want.value);
          if (out_tuser !== want.status)
            report_mismatch("status", DW'(out_tuser), DW'(want.status));
          if (out_tlast !== want.last)
            report_mismatch("last", DW'(out_tlast), DW'(want.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (samples_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 9) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    add_sample(32'h0000_0000, 1'b0, 1'b0);
    add_sample(32'h0000_0001, 1'b0, 1'b0);
    add_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    add_sample(32'h0001_0000, 1'b0, 1'b0);
    add_sample(32'h000A_0000, 1'b0, 1'b0);
    add_sample(32'h0000_8000, 1'b0, 1'b0);
    add_sample(32'h0000_0002, 1'b0, 1'b0);
    add_sample(32'h0000_FFFF, 1'b0, 1'b0);
    add_sample(32'h8000_0000, 1'b0, 1'b0);
    add_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    add_sample(32'h0000_0000, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_sample(32'h0064_0000, 1'b0, 1'b0);
    add_sample(32'hFFFF_0000, 1'b1, 1'b0);
    add_sample(32'h0001_0000, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_sample(32'h1234_5678, 1'b1, 1'b0);
    add_sample(32'h0000_0000, 1'b1, 1'b0);
    add_matrix(1'b1);
    while (samples_q.size() < 250) add_matrix(1'b0);
    add_matrix(1'b1);
    while (samples_q.size() < 500) add_matrix(1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (samples_q.size() != 0 || results_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* elementwise_log10_stream_core.f */
design/elog10_pkg.sv
design/elog10_norm.sv
design/elog10_sqlog.sv
design/elog10_scale.sv
design/elementwise_log10_stream_core.sv
test/tb.sv
